/* design/pdm_pkg.sv */
// ----------------------------------------------------------------------------
// pdm_pkg: shared types, constants and helpers for pool2d_max_mean.
// Holds the sequencer states, register indexes and the window edge test.
// ----------------------------------------------------------------------------
package pdm_pkg;

    localparam int CFG_W = 14;
    localparam int IDX_W = 3;
    localparam int LW = 9;
    localparam int SW = 13;
    localparam int OCW = 7;
    localparam int MAX_RESULTS = 64;

    localparam logic [IDX_W-1:0] CFG_IN_DIMS = 3'd0;
    localparam logic [IDX_W-1:0] CFG_KERNEL_DIMS = 3'd1;
    localparam logic [IDX_W-1:0] CFG_STRIDE_DIMS = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PAD_TOP_LEFT = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OUT_DIMS = 3'd4;
    localparam logic [IDX_W-1:0] CFG_POOL_MODE = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_LIMIT,
        ST_ROW,
        ST_COL,
        ST_RD,
        ST_ACC,
        ST_DIV,
        ST_FIX,
        ST_OUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic hit;
        logic signed [SW-1:0] start;
    } axis_t;

    function automatic logic [LW-1:0] clamp_size(input logic [OCW-1:0] v,
                                                 input logic [LW-1:0] lim);
        logic [LW-1:0] w;
        begin
            w = LW'(v);
            if (w == '0)
                clamp_size = LW'(1);
            else if (w > lim)
                clamp_size = lim;
            else
                clamp_size = w;
        end
    endfunction

    function automatic logic signed [SW-1:0] to_sw(input logic [LW-1:0] v);
        to_sw = $signed(SW'(v));
    endfunction

    function automatic axis_t axis_hit(input logic signed [SW-1:0] s,
                                       input logic signed [SW-1:0] k,
                                       input logic signed [SW-1:0] size,
                                       input logic signed [SW-1:0] pos);
        logic signed [SW-1:0] e;
        logic signed [SW-1:0] st;
        axis_t r;
        begin
            e = s + k;
            if (e > size)
                e = size;
            st = (s < 0) ? '0 : s;
            r.hit = (st < e) && ((e - SW'(1)) == pos);
            r.start = st;
            axis_hit = r;
        end
    endfunction

endpackage

/* design/pool2d_max_mean.sv */
// ----------------------------------------------------------------------------
// pool2d_max_mean: streaming 2-D max and mean pooling over one plane.
// Stores each raster-order sample and emits the windows it completes, up to MAX_RESULTS per sample.
// ----------------------------------------------------------------------------
// Each accepted word is written into the plane memory; the block then stalls
// its input while one sequencer finds the windows whose clipped bottom-right
// corner is this position and reduces each one through a single shared
// add/compare unit fed by one registered memory read port. For each sample
// the sequencer first counts the matching output rows and columns, then scans
// them, reads and reduces each in-image sample of a matched window, divides
// the sum in a restoring bit-serial divider for mean pooling, and hands out
// each result word. The plane memory holds MAX_DIM*MAX_DIM entries and needs
// no clearing after reset.
module pool2d_max_mean #(
    parameter int MAX_DIM = 64,
    parameter int MAX_KERNEL = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [pdm_pkg::IDX_W-1:0] cfg_index,
    input  logic [pdm_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [SAMPLE_BITS-1:0] pooled_value,
    output logic [5:0] out_row,
    output logic [5:0] out_col,
    output logic run_last
);

    localparam int POSW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SZW = $clog2(MAX_DIM + 1);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AXW = POSW + SZW + 1;
    localparam int SUMW = SAMPLE_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int CW = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int ITW = $clog2(SUMW + 1);
    localparam int LW = pdm_pkg::LW;
    localparam int SW = pdm_pkg::SW;
    localparam int OCW = pdm_pkg::OCW;

    pdm_pkg::state_t state_reg, state_next;

    logic [13:0] in_dims_reg;
    logic [7:0] kernel_dims_reg, stride_dims_reg;
    logic [5:0] pad_reg;
    logic [13:0] out_dims_reg;
    logic mode_reg;

    logic [POSW-1:0] row_pos_reg, row_pos_next, col_pos_reg, col_pos_next;
    logic [OCW-1:0] ro_reg, ro_next, co_reg, co_next;
    logic signed [SW-1:0] rs_reg, rs_next, cs_reg, cs_next;
    logic [OCW-1:0] nr_reg, nr_next, nc_reg, nc_next;
    logic [OCW-1:0] limit_reg, limit_next, cnt_reg, cnt_next;
    logic [POSW-1:0] r0_reg, r0_next, c0_reg, c0_next;
    logic [POSW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [SUMW-1:0] acc_reg, acc_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SUMW-1:0] quo_reg, quo_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [ITW-1:0] it_reg, it_next;
    logic neg_reg, neg_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic [5:0] orow_reg, orow_next, ocol_reg, ocol_next;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    logic [LW-1:0] ih, iw, oh, ow, olim, kh, kw;
    logic [3:0] sh, sw;
    logic [SZW-1:0] iw_n;
    logic [AXW-1:0] waddr_w, raddr_w;
    logic in_accept, out_accept;
    pdm_pkg::axis_t rhit, chit;
    logic signed [SUMW-1:0] val, acc_upd;
    logic [SUMW-1:0] acc_mag;
    logic [CW:0] trial;
    logic trial_ge;
    logic [13:0] total;
    logic win_end, is_last;

    assign ih = pdm_pkg::clamp_size(in_dims_reg[13:7], LW'(MAX_DIM));
    assign iw = pdm_pkg::clamp_size(in_dims_reg[6:0], LW'(MAX_DIM));
    assign oh = pdm_pkg::clamp_size(out_dims_reg[13:7], LW'(MAX_DIM));
    assign ow = pdm_pkg::clamp_size(out_dims_reg[6:0], LW'(MAX_DIM));
    assign kh = pdm_pkg::clamp_size({3'b000, kernel_dims_reg[7:4]}, LW'(MAX_KERNEL));
    assign kw = pdm_pkg::clamp_size({3'b000, kernel_dims_reg[3:0]}, LW'(MAX_KERNEL));
    assign sh = (stride_dims_reg[7:4] == 4'd0) ? 4'd1 : stride_dims_reg[7:4];
    assign sw = (stride_dims_reg[3:0] == 4'd0) ? 4'd1 : stride_dims_reg[3:0];
    assign olim = (oh > ow) ? oh : ow;
    assign iw_n = iw[SZW-1:0];

    assign waddr_w = AXW'(row_pos_reg) * AXW'(iw_n) + AXW'(col_pos_reg);
    assign raddr_w = AXW'(x_reg) * AXW'(iw_n) + AXW'(y_reg);

    assign rhit = pdm_pkg::axis_hit(rs_reg, pdm_pkg::to_sw(kh), pdm_pkg::to_sw(ih),
                                    pdm_pkg::to_sw(LW'(row_pos_reg)));
    assign chit = pdm_pkg::axis_hit(cs_reg, pdm_pkg::to_sw(kw), pdm_pkg::to_sw(iw),
                                    pdm_pkg::to_sw(LW'(col_pos_reg)));

    assign in_accept = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    assign val = SUMW'(rdata_reg);
    assign acc_upd = mode_reg ? (acc_reg + val) : ((val > acc_reg) ? val : acc_reg);
    assign acc_mag = acc_upd[SUMW-1] ? SUMW'(-acc_upd) : SUMW'(acc_upd);
    assign trial = {rem_reg, quo_reg[SUMW-1]};
    assign trial_ge = trial >= (CW+1)'(n_reg);
    assign total = 14'(nr_reg) * 14'(nc_reg);
    assign win_end = (y_reg == col_pos_reg) && (x_reg == row_pos_reg);
    assign is_last = (OCW'(cnt_reg + OCW'(1)) == limit_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdm_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pdm_pkg::ST_COUNT;
            pdm_pkg::ST_COUNT:
                if (LW'(ro_reg) == olim)
                    state_next = pdm_pkg::ST_LIMIT;
            pdm_pkg::ST_LIMIT:
                state_next = (total == '0) ? pdm_pkg::ST_DONE : pdm_pkg::ST_ROW;
            pdm_pkg::ST_ROW:
                if (LW'(ro_reg) == oh)
                    state_next = pdm_pkg::ST_DONE;
                else if (rhit.hit)
                    state_next = pdm_pkg::ST_COL;
            pdm_pkg::ST_COL:
                if (LW'(co_reg) == ow)
                    state_next = pdm_pkg::ST_ROW;
                else if (chit.hit)
                    state_next = pdm_pkg::ST_RD;
            pdm_pkg::ST_RD:
                state_next = pdm_pkg::ST_ACC;
            pdm_pkg::ST_ACC:
                if (!win_end)
                    state_next = pdm_pkg::ST_RD;
                else if (mode_reg)
                    state_next = pdm_pkg::ST_DIV;
                else
                    state_next = pdm_pkg::ST_OUT;
            pdm_pkg::ST_DIV:
                if (it_reg == ITW'(1))
                    state_next = pdm_pkg::ST_FIX;
            pdm_pkg::ST_FIX:
                state_next = pdm_pkg::ST_OUT;
            pdm_pkg::ST_OUT:
                if (!out_stall)
                    state_next = is_last ? pdm_pkg::ST_DONE : pdm_pkg::ST_COL;
            pdm_pkg::ST_DONE:
                state_next = pdm_pkg::ST_IDLE;
            default:
                state_next = pdm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        ro_next = ro_reg;
        co_next = co_reg;
        rs_next = rs_reg;
        cs_next = cs_reg;
        nr_next = nr_reg;
        nc_next = nc_reg;
        limit_next = limit_reg;
        cnt_next = cnt_reg;
        r0_next = r0_reg;
        c0_next = c0_reg;
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        n_next = n_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        it_next = it_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        in_stall = (state_reg != pdm_pkg::ST_IDLE);
        out_valid = (state_reg == pdm_pkg::ST_OUT);
        case (state_reg)
            pdm_pkg::ST_IDLE:
            begin
                ro_next = '0;
                rs_next = -pdm_pkg::to_sw(LW'(pad_reg[5:3]));
                cs_next = -pdm_pkg::to_sw(LW'(pad_reg[2:0]));
                nr_next = '0;
                nc_next = '0;
            end
            pdm_pkg::ST_COUNT:
            begin
                if (LW'(ro_reg) < oh && rhit.hit)
                    nr_next = nr_reg + OCW'(1);
                if (LW'(ro_reg) < ow && chit.hit)
                    nc_next = nc_reg + OCW'(1);
                ro_next = ro_reg + OCW'(1);
                rs_next = rs_reg + SW'(sh);
                cs_next = cs_reg + SW'(sw);
            end
            pdm_pkg::ST_LIMIT:
            begin
                limit_next = (total >= 14'(pdm_pkg::MAX_RESULTS))
                             ? OCW'(pdm_pkg::MAX_RESULTS) : total[OCW-1:0];
                cnt_next = '0;
                ro_next = '0;
                rs_next = -pdm_pkg::to_sw(LW'(pad_reg[5:3]));
            end
            pdm_pkg::ST_ROW:
            begin
                if (LW'(ro_reg) != oh)
                begin
                    ro_next = ro_reg + OCW'(1);
                    rs_next = rs_reg + SW'(sh);
                    r0_next = rhit.start[POSW-1:0];
                    orow_next = ro_reg[5:0];
                    co_next = '0;
                    cs_next = -pdm_pkg::to_sw(LW'(pad_reg[2:0]));
                end
            end
            pdm_pkg::ST_COL:
            begin
                if (LW'(co_reg) != ow)
                begin
                    co_next = co_reg + OCW'(1);
                    cs_next = cs_reg + SW'(sw);
                    c0_next = chit.start[POSW-1:0];
                    ocol_next = co_reg[5:0];
                    x_next = r0_reg;
                    y_next = chit.start[POSW-1:0];
                    acc_next = mode_reg ? '0
                               : SUMW'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}));
                    n_next = '0;
                end
            end
            pdm_pkg::ST_ACC:
            begin
                acc_next = acc_upd;
                n_next = n_reg + CW'(1);
                if (y_reg == col_pos_reg)
                begin
                    x_next = x_reg + POSW'(1);
                    y_next = c0_reg;
                end
                else
                    y_next = y_reg + POSW'(1);
                res_next = acc_upd[SAMPLE_BITS-1:0];
                quo_next = acc_mag;
                rem_next = '0;
                it_next = ITW'(SUMW);
                neg_next = acc_upd[SUMW-1];
            end
            pdm_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? CW'(trial - (CW+1)'(n_reg)) : trial[CW-1:0];
                quo_next = {quo_reg[SUMW-2:0], trial_ge};
                it_next = it_reg - ITW'(1);
            end
            pdm_pkg::ST_FIX:
                res_next = neg_reg ? -quo_reg[SAMPLE_BITS-1:0] : quo_reg[SAMPLE_BITS-1:0];
            pdm_pkg::ST_OUT:
                if (!out_stall)
                    cnt_next = cnt_reg + OCW'(1);
            pdm_pkg::ST_DONE:
            begin
                if (LW'(col_pos_reg) >= iw - LW'(1))
                begin
                    col_pos_next = '0;
                    if (LW'(row_pos_reg) >= ih - LW'(1))
                        row_pos_next = '0;
                    else
                        row_pos_next = row_pos_reg + POSW'(1);
                end
                else
                    col_pos_next = col_pos_reg + POSW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign pooled_value = res_reg;
    assign out_row = orow_reg;
    assign out_col = ocol_reg;
    assign run_last = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_dims_reg <= 14'd8256;
            kernel_dims_reg <= 8'd34;
            stride_dims_reg <= 8'd34;
            pad_reg <= 6'd0;
            out_dims_reg <= 14'd4128;
            mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pdm_pkg::CFG_IN_DIMS: in_dims_reg <= cfg_data;
                pdm_pkg::CFG_KERNEL_DIMS: kernel_dims_reg <= cfg_data[7:0];
                pdm_pkg::CFG_STRIDE_DIMS: stride_dims_reg <= cfg_data[7:0];
                pdm_pkg::CFG_PAD_TOP_LEFT: pad_reg <= cfg_data[5:0];
                pdm_pkg::CFG_OUT_DIMS: out_dims_reg <= cfg_data;
                pdm_pkg::CFG_POOL_MODE: mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdm_pkg::ST_IDLE;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            cnt_reg <= '0;
            limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            cnt_reg <= cnt_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ro_reg <= ro_next;
        co_reg <= co_next;
        rs_reg <= rs_next;
        cs_reg <= cs_next;
        nr_reg <= nr_next;
        nc_reg <= nc_next;
        r0_reg <= r0_next;
        c0_reg <= c0_next;
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        n_reg <= n_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        it_reg <= it_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            mem[waddr_w[AW-1:0]] <= sample;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr_w[AW-1:0]];
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == pdm_pkg::ST_COUNT)
        else $error("accepted word did not start a match count");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && run_last) |=> (!out_valid && state_reg == pdm_pkg::ST_DONE))
        else $error("work continued after the last result word");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg < limit_reg && limit_reg <= OCW'(pdm_pkg::MAX_RESULTS)))
        else $error("result count out of range");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pdm_pkg::ST_DIV |-> (n_reg != '0 && mode_reg))
        else $error("divider started without samples");
`endif

endmodule

/* sim/tb_pool2d_max_mean.sv */
// ----------------------------------------------------------------------------
// tb_pool2d_max_mean: self-checking testbench for pool2d_max_mean.
// A clocked driver offers samples from a queue of pending words. Each accepted
// sample runs through a behavioral pooling model that queues the windows it
// completes. A clocked monitor compares every result word with the oldest
// queued window. Phases change the window setup while the block is idle and
// vary idling on both sides.
// ----------------------------------------------------------------------------
module tb_pool2d_max_mean;

    localparam int PLANE_DEPTH = 4096;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [15:0] value;
        logic [5:0] row;
        logic [5:0] col;
        logic last;
    } window_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [pdm_pkg::IDX_W-1:0] cfg_index = pdm_pkg::CFG_IN_DIMS;
    logic [pdm_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] sample;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] pooled_value;
    logic [5:0] out_row;
    logic [5:0] out_col;
    logic run_last;

    logic [13:0] in_dims_q = 14'd8256;
    logic [7:0] kernel_q = 8'd34;
    logic [7:0] stride_q = 8'd34;
    logic [5:0] pad_q = 6'd0;
    logic [13:0] out_dims_q = 14'd4128;
    logic mode_q = 1'b0;

    logic signed [15:0] plane_mem [PLANE_DEPTH];
    int row_pos = 0;
    int col_pos = 0;

    logic signed [15:0] pending_words[$];
    window_t windows_due[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;
    logic hold_start = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    pool2d_max_mean dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pooled_value(pooled_value),
        .out_row(out_row),
        .out_col(out_col),
        .run_last(run_last)
    );

    always #6 clk = ~clk;

    function automatic int clampv(input int v, input int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %0s: got %0d, want %0d (row %0d col %0d)", what, got, want,
                 row_pos, col_pos);
        errors++;
    endtask

    task automatic pool_sample(input logic signed [15:0] s);
        int ih, iw, kh, kw, sh, sw, pt, pl, oh, ow;
        int nr, nc, cnt, st, e;
        int rows[64], rst[64], cols[64], cst[64];
        longint acc, n;
        window_t w;
        ih = clampv(int'(in_dims_q[13:7]), 64);
        iw = clampv(int'(in_dims_q[6:0]), 64);
        kh = clampv(int'(kernel_q[7:4]), 8);
        kw = clampv(int'(kernel_q[3:0]), 8);
        sh = clampv(int'(stride_q[7:4]), 15);
        sw = clampv(int'(stride_q[3:0]), 15);
        pt = int'(pad_q[5:3]);
        pl = int'(pad_q[2:0]);
        oh = clampv(int'(out_dims_q[13:7]), 64);
        ow = clampv(int'(out_dims_q[6:0]), 64);
        plane_mem[(row_pos * iw + col_pos) % PLANE_DEPTH] = s;
        nr = 0;
        for (int o = 0; o < oh; o++)
        begin
            st = o * sh - pt;
            e = (st + kh > ih) ? ih : st + kh;
            if (st < 0)
                st = 0;
            if (st < e && e - 1 == row_pos)
            begin
                rows[nr] = o;
                rst[nr] = st;
                nr++;
            end
        end
        nc = 0;
        for (int o = 0; o < ow; o++)
        begin
            st = o * sw - pl;
            e = (st + kw > iw) ? iw : st + kw;
            if (st < 0)
                st = 0;
            if (st < e && e - 1 == col_pos)
            begin
                cols[nc] = o;
                cst[nc] = st;
                nc++;
            end
        end
        cnt = 0;
        for (int a = 0; a < nr; a++)
        begin
            for (int b = 0; b < nc; b++)
            begin
                if (cnt < pdm_pkg::MAX_RESULTS)
                begin
                    acc = mode_q ? 0 : -32768;
                    n = 0;
                    for (int x = rst[a]; x <= row_pos; x++)
                    begin
                        for (int y = cst[b]; y <= col_pos; y++)
                        begin
                            if (mode_q)
                                acc += plane_mem[(x * iw + y) % PLANE_DEPTH];
                            else if (plane_mem[(x * iw + y) % PLANE_DEPTH] > acc)
                                acc = plane_mem[(x * iw + y) % PLANE_DEPTH];
                            n++;
                        end
                    end
                    if (mode_q && n > 0)
                        acc = acc / n;
                    w.value = acc[15:0];
                    w.row = rows[a][5:0];
                    w.col = cols[b][5:0];
                    w.last = 1'b0;
                    windows_due.push_back(w);
                    cnt++;
                end
            end
        end
        if (cnt > 0)
            windows_due[windows_due.size() - 1].last = 1'b1;
        if (col_pos >= iw - 1)
        begin
            col_pos = 0;
            row_pos = (row_pos >= ih - 1) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pool_sample(sample);
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    sample <= pending_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start != hold_seen)
        begin
            hold_seen <= hold_start;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        window_t w;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (windows_due.size() == 0)
                    report("unexpected word", pooled_value, 0);
                else
                begin
                    w = windows_due.pop_front();
                    if (pooled_value !== w.value)
                        report("pooled_value", pooled_value, w.value);
                    if (out_row !== w.row)
                        report("out_row", out_row, w.row);
                    if (out_col !== w.col)
                        report("out_col", out_col, w.col);
                    if (run_last !== w.last)
                        report("run_last", run_last, w.last);
                end
            end
            out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[pool2d_max_mean] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [pdm_pkg::IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[pdm_pkg::CFG_W-1:0];
        case (idx)
            pdm_pkg::CFG_IN_DIMS: in_dims_q = val[13:0];
            pdm_pkg::CFG_KERNEL_DIMS: kernel_q = val[7:0];
            pdm_pkg::CFG_STRIDE_DIMS: stride_q = val[7:0];
            pdm_pkg::CFG_PAD_TOP_LEFT: pad_q = val[5:0];
            pdm_pkg::CFG_OUT_DIMS: out_dims_q = val[13:0];
            default: mode_q = val[0];
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic setup(input int ih, input int iw, input int kern, input int strd,
                         input int pad, input int oh, input int ow, input int mode);
        write_reg(pdm_pkg::CFG_IN_DIMS, (ih << 7) | iw);
        write_reg(pdm_pkg::CFG_KERNEL_DIMS, kern);
        write_reg(pdm_pkg::CFG_STRIDE_DIMS, strd);
        write_reg(pdm_pkg::CFG_PAD_TOP_LEFT, pad);
        write_reg(pdm_pkg::CFG_OUT_DIMS, (oh << 7) | ow);
        write_reg(pdm_pkg::CFG_POOL_MODE, mode);
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || windows_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_words(input int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(rand_word());
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0; recv_idle_pct = 0; end
            1: begin send_idle_pct = 82; recv_idle_pct = 0; end
            2: begin send_idle_pct = 0; recv_idle_pct = 82; end
            default: begin send_idle_pct = 19; recv_idle_pct = 19; end
        endcase
    endtask

    task automatic random_phase(input int phase, input int ih, input int iw);
        int kh, kw, sh, sw, pt, pl, pb, pr, oh, ow, num, kern, strd, pad, outd, n;
        kh = $urandom_range(1, 4);
        kw = $urandom_range(1, 4);
        sh = $urandom_range(1, 3);
        sw = $urandom_range(1, 3);
        pt = $urandom_range(0, kh - 1);
        pl = $urandom_range(0, kw - 1);
        pb = $urandom_range(0, kh - 1);
        pr = $urandom_range(0, kw - 1);
        num = ih + pt + pb - kh;
        oh = (num < 0) ? 1 : ($urandom_range(1) ? num / sh : (num + sh - 1) / sh) + 1;
        num = iw + pl + pr - kw;
        ow = (num < 0) ? 1 : ($urandom_range(1) ? num / sw : (num + sw - 1) / sw) + 1;
        kern = (kh << 4) | kw;
        strd = (sh << 4) | sw;
        pad = (pt << 3) | pl;
        outd = (oh << 7) | ow;
        case ($urandom_range(7))
            0: kern = $urandom_range(255);
            1: strd = $urandom_range(255);
            2: pad = $urandom_range(63);
            3: outd = $urandom_range(16383);
            4: begin kern = 8'hf0 | kw; strd = 8'h00; end
            default: ;
        endcase
        set_idling(phase);
        write_reg(pdm_pkg::CFG_IN_DIMS, (ih << 7) | iw);
        write_reg(pdm_pkg::CFG_KERNEL_DIMS, kern);
        write_reg(pdm_pkg::CFG_STRIDE_DIMS, strd);
        write_reg(pdm_pkg::CFG_PAD_TOP_LEFT, pad);
        write_reg(pdm_pkg::CFG_OUT_DIMS, outd);
        write_reg(pdm_pkg::CFG_POOL_MODE, $urandom_range(1));
        n = clampv(ih, 64) * clampv(iw, 64);
        send_words(n);
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < PLANE_DEPTH; i++)
            plane_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes through max and mean pooling on a 3x3 plane.
        setup(3, 3, 8'h22, 8'h11, 0, 2, 2, 0);
        pending_words = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                          16'sh8000, 16'sh0000, -16'sd1, 16'sd1};
        wait_idle();
        write_reg(pdm_pkg::CFG_POOL_MODE, 1);
        pending_words = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                          16'sh8000, -16'sd3, 16'sd1, 16'sd0};
        wait_idle();
        // Padding on all sides: edge windows hold fewer samples.
        setup(3, 3, 8'h33, 8'h11, 6'o11, 3, 3, 1);
        pending_words = '{-16'sd7, 16'sd5, -16'sd2, 16'sh8000, 16'sd9, 16'sd4,
                          16'sd1, -16'sd1, 16'sh7fff};
        wait_idle();
        // Padding not below the kernel leaves windows with no sample.
        setup(2, 2, 8'h22, 8'h11, 6'o22, 3, 3, 0);
        send_words(4);
        wait_idle();
        // Zero and oversize sizes on a single row and a single column.
        setup(0, 127, 8'h0f, 8'h0f, 0, 1, 64, 0);
        send_words(64);
        wait_idle();
        setup(127, 0, 8'hf0, 8'h10, 0, 64, 0, 1);
        send_words(64);
        wait_idle();
        // A shrink mid-plane leaves the position outside the image.
        setup(4, 6, 8'h22, 8'h22, 0, 2, 3, 1);
        send_words(10);
        wait_idle();
        write_reg(pdm_pkg::CFG_IN_DIMS, (2 << 7) | 2);
        write_reg(pdm_pkg::CFG_OUT_DIMS, (1 << 7) | 1);
        send_words(5);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
            begin
                hold_start <= ~hold_start;
                random_phase(phase, 4, 4);
            end
            else
                random_phase(phase, $urandom_range(1, 6), $urandom_range(1, 8));
        end

        if (windows_due.size() > 0)
            report("windows left over", windows_due.size(), 0);
        if (errors == 0)
            $display("[pool2d_max_mean] OK");
        else
            $display("[pool2d_max_mean] ERROR");
        $finish;
    end

endmodule

/* files.f */
design/pdm_pkg.sv
design/pool2d_max_mean.sv
sim/tb_pool2d_max_mean.sv
